// ===== rtl/mcc_pkg.sv =====
package mcc_pkg;

    localparam int PIXEL_W    = 8;
    localparam int THRESH_W   = 11;
    localparam int DIVIDEND_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [PIXEL_W-1:0] PIXEL_MAX   = 8'd255;
    localparam logic [PIXEL_W-1:0] DIFF_CENTRE = 8'd127;
    localparam logic [PIXEL_W-1:0] MIN_DIVISOR = 8'd30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD       = 2'd0,
        REG_COMBINE_MODE    = 2'd1,
        REG_PEAK_DIFFERENCE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] diff_pixel;
        logic [PIXEL_W-1:0] class_pixel;
        logic               last_in;
    } mcc_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] combined_pixel;
        logic               last_out;
    } mcc_out_t;

    // Classified item passed from the front end to the divider
    typedef struct packed {
        logic                  last;
        logic                  div_en;
        logic [DIVIDEND_W-1:0] dividend;
    } mcc_work_t;

    typedef struct packed {
        logic                  last;
        logic                  div_en;
        logic [PIXEL_W-1:0]    rem;
        logic [DIVIDEND_W-1:0] num;
    } mcc_div_stage_t;

endpackage

// ===== rtl/mcc_front.sv =====
module mcc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  mcc_pkg::mcc_in_t              in_item,
    input  logic                          combine_mode,
    input  logic [mcc_pkg::PIXEL_W-1:0]   peak_difference,
    input  logic                          queue_full,
    output logic                          push,
    output mcc_pkg::mcc_work_t            work
);

    logic                          vld_reg;
    logic                          vld_next;
    mcc_pkg::mcc_work_t            work_reg;
    mcc_pkg::mcc_work_t            work_next;
    logic                          accept;
    logic [mcc_pkg::PIXEL_W-1:0]   dval;
    logic [mcc_pkg::PIXEL_W:0]     pix_sum;

    assign busy   = vld_reg && queue_full;
    assign accept = start && !busy;
    assign push   = vld_reg && !queue_full;
    assign work   = work_reg;

    always_comb
    begin
        if (peak_difference == mcc_pkg::PIXEL_MAX)
        begin
            dval = in_item.diff_pixel;
        end
        else if (in_item.diff_pixel >= mcc_pkg::DIFF_CENTRE)
        begin
            dval = in_item.diff_pixel - mcc_pkg::DIFF_CENTRE;
        end
        else
        begin
            dval = mcc_pkg::DIFF_CENTRE - in_item.diff_pixel;
        end

        pix_sum = {1'b0, dval} + {1'b0, in_item.class_pixel};

        work_next.last = in_item.last_in;
        if (combine_mode)
        begin
            work_next.div_en   = 1'b1;
            work_next.dividend = mcc_pkg::DIVIDEND_W'(dval)
                               * mcc_pkg::DIVIDEND_W'(in_item.class_pixel);
        end
        else
        begin
            // average needs no divider: halve here, bypass the quotient path
            work_next.div_en   = 1'b0;
            work_next.dividend = mcc_pkg::DIVIDEND_W'(pix_sum[mcc_pkg::PIXEL_W:1]);
        end
    end

    assign vld_next = accept || (vld_reg && !push);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            work_reg <= work_next;
        end
    end

endmodule

// ===== rtl/mcc_queue.sv =====
module mcc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  mcc_pkg::mcc_work_t   push_item,
    output logic                 full,
    output logic                 head_vld,
    output mcc_pkg::mcc_work_t   head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mcc_pkg::mcc_work_t  mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                pop;

    // the back end never stalls, so drain whenever an entry is held
    assign pop       = (count_reg != '0);
    assign head_vld  = pop;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/mcc_back.sv =====
module mcc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_vld,
    input  mcc_pkg::mcc_work_t            item,
    input  logic [mcc_pkg::PIXEL_W-1:0]   divisor,
    input  logic [mcc_pkg::THRESH_W-1:0]  threshold,
    output logic                          done,
    output mcc_pkg::mcc_out_t             out_item
);

    localparam int N = mcc_pkg::DIVIDEND_W;
    localparam int W = mcc_pkg::PIXEL_W;

    mcc_pkg::mcc_div_stage_t  stg_reg  [N];
    mcc_pkg::mcc_div_stage_t  stg_next [N];
    logic [N-1:0]             vld_reg;
    logic                     done_reg;
    mcc_pkg::mcc_out_t        out_reg;
    mcc_pkg::mcc_out_t        out_next;
    logic [N-1:0]             value;

    // restoring division, one quotient bit per stage
    for (genvar s = 0; s < N; s++)
    begin : g_stage
        mcc_pkg::mcc_div_stage_t  src;
        logic [W:0]               trial;
        logic                     ge;

        if (s == 0)
        begin : g_first
            always_comb
            begin
                src.last   = item.last;
                src.div_en = item.div_en;
                src.rem    = '0;
                src.num    = item.dividend;
            end
        end
        else
        begin : g_rest
            assign src = stg_reg[s-1];
        end

        always_comb
        begin
            trial       = {src.rem, src.num[N-1]};
            ge          = (trial >= {1'b0, divisor});
            stg_next[s] = src;
            if (src.div_en)
            begin
                stg_next[s].num = {src.num[N-2:0], ge};
                stg_next[s].rem = ge ? W'(trial - {1'b0, divisor}) : trial[W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[s] <= 1'b0;
            end
            else
            begin
                vld_reg[s] <= (s == 0) ? item_vld : vld_reg[(s == 0) ? 0 : s - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            stg_reg[s] <= stg_next[s];
        end
    end

    assign value = stg_reg[N-1].num;

    always_comb
    begin
        out_next.last_out = stg_reg[N-1].last;
        if (threshold != '0)
        begin
            out_next.combined_pixel = (value > N'(threshold)) ? mcc_pkg::PIXEL_MAX : '0;
        end
        else if (value > N'(mcc_pkg::PIXEL_MAX))
        begin
            out_next.combined_pixel = mcc_pkg::PIXEL_MAX;
        end
        else
        begin
            out_next.combined_pixel = value[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[N-1];
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done     = done_reg;
    assign out_item = out_reg;

endmodule

// ===== rtl/motion_color_combiner.sv =====
// Motion and colour combiner: merges a difference-image pixel with a colour
// classification pixel, one pixel per clock while busy is low.
//
// Input: a pixel transfer happens on a rising edge with start high and busy
// low; in_item carries diff_pixel, class_pixel and last_in.
// Output: done is high for exactly one cycle with out_item valid; the
// receiver cannot hold results off, and none is needed since the block never
// back-pressures its output.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (threshold, combine_mode, peak_difference); indexes beyond those are
// ignored. Write only while no pixel is in flight.
// Path: done rises once the pixel has passed the front register, the queue,
// the 16 divider stages and the output register.
// Throughput: one pixel per clock; the 16-stage restoring divider is fully
// pipelined, so busy stays low in normal use.
// Reset: clears the pipeline and loads threshold 0, average mode and
// peak 255.
module motion_color_combiner #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  mcc_pkg::mcc_in_t                in_item,
    output logic                            done,
    output mcc_pkg::mcc_out_t               out_item,
    input  logic                            cfg_we,
    input  logic [mcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [mcc_pkg::THRESH_W-1:0]  threshold_reg;
    logic                          combine_mode_reg;
    logic [mcc_pkg::PIXEL_W-1:0]   peak_reg;
    logic [mcc_pkg::PIXEL_W-1:0]   divisor;
    logic                          queue_full;
    logic                          push;
    mcc_pkg::mcc_work_t            front_work;
    logic                          head_vld;
    mcc_pkg::mcc_work_t            head_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= '0;
            combine_mode_reg <= 1'b0;
            peak_reg         <= mcc_pkg::PIXEL_MAX;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcc_pkg::REG_THRESHOLD:
                begin
                    threshold_reg <= cfg_data[mcc_pkg::THRESH_W-1:0];
                end
                mcc_pkg::REG_COMBINE_MODE:
                begin
                    combine_mode_reg <= cfg_data[0];
                end
                mcc_pkg::REG_PEAK_DIFFERENCE:
                begin
                    peak_reg <= cfg_data[mcc_pkg::PIXEL_W-1:0];
                end
                default:
                begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // a peak of 255 gives 255 here too, which covers the binary case
    assign divisor = (peak_reg < mcc_pkg::MIN_DIVISOR) ? mcc_pkg::MIN_DIVISOR : peak_reg;

    mcc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .in_item         (in_item),
        .combine_mode    (combine_mode_reg),
        .peak_difference (peak_reg),
        .queue_full      (queue_full),
        .push            (push),
        .work            (front_work)
    );

    mcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_work),
        .full      (queue_full),
        .head_vld  (head_vld),
        .head_item (head_item)
    );

    mcc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_vld  (head_vld),
        .item      (head_item),
        .divisor   (divisor),
        .threshold (threshold_reg),
        .done      (done),
        .out_item  (out_item)
    );

endmodule
